>>> rtl/lrss_pkg.sv
package lrss_pkg;

   localparam int BUCKETS    = 95;
   localparam int BW         = $clog2(BUCKETS);
   localparam int FIRST_CODE = 32;
   localparam int LAST_CODE  = 126;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_SORT = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NO_READ = 2'd2;
   localparam logic [1:0] ST_PARTIAL = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_LOAD, S_NOP, S_RD0, S_RD1, S_RD2,
      S_SETUP, S_CHK, S_INIT, S_CLR,
      S_CNT0, S_CNT1, S_CNT2, S_CNT3,
      S_PFX0, S_PFX1,
      S_SCT0, S_SCT1, S_SCT2, S_SCT3,
      S_CPY0, S_CPY1, S_DONE
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_DIV, OP_LOAD, OP_NOP, OP_RD0, OP_RD1, OP_RD2,
      OP_SETUP, OP_INIT, OP_CLR,
      OP_CNT0, OP_CNT1, OP_CNT2, OP_CNT3,
      OP_PFX0, OP_PFX1,
      OP_SCT0, OP_SCT1, OP_SCT2, OP_SCT3,
      OP_CPY0, OP_CPY1, OP_DONE
   } dp_op_type;

   typedef struct packed {
      logic      accept;
      logic      cfg_write;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic can_read;
      logic n_zero;
      logic i_last;
      logic b_last;
      logic p_zero;
      logic div_last;
   } dp_status_type;

endpackage

>>> rtl/lsd_radix_string_sorter_core.sv
// Load and no-op requests go through S_LOAD or S_NOP to a registered rsp_valid; busy is
// low again when it rises. Read: S_RD0 reads the order RAM, S_RD1 the store RAM, S_RD2
// returns the character; S_RD0 alone answers when nothing is left to read. A sort walks
// the order, store and bucket RAMs one access per cycle. A csr write holds busy for the
// string-count divider. Synchronous active-high reset; RAM contents are not reset.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
module lsd_radix_string_sorter_core #(
   parameter int MAX_STRINGS = 256,
   parameter int MAX_LEN     = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [6:0] req_char_code,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data,
   output logic       rsp_valid,
   output logic [6:0] rsp_out_char,
   output logic       rsp_end_of_string,
   output logic       rsp_end_of_set,
   output logic [8:0] rsp_strings_held,
   output logic [1:0] rsp_status
);

   lrss_pkg::dp_cmd_type    cmd;
   lrss_pkg::dp_status_type stat;

   lrss_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_type(req_type),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .busy(busy),
      .cmd(cmd), .stat(stat)
   );

   lrss_datapath #(.MAX_STRINGS(MAX_STRINGS), .MAX_LEN(MAX_LEN)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_char_code(req_char_code), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_out_char(rsp_out_char),
      .rsp_end_of_string(rsp_end_of_string), .rsp_end_of_set(rsp_end_of_set),
      .rsp_strings_held(rsp_strings_held), .rsp_status(rsp_status)
   );

endmodule

>>> rtl/lrss_ram.sv
module lrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/lrss_ctrl.sv
module lrss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_type,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output logic                   busy,
   output lrss_pkg::dp_cmd_type    cmd,
   input  lrss_pkg::dp_status_type stat
);

   lrss_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.cfg_write = 1'b0;
      cmd.op        = lrss_pkg::OP_NONE;
      busy          = 1'b1;
      csr_ready     = 1'b0;
      unique case (state_ff)
         lrss_pkg::S_IDLE: begin
            busy      = 1'b0;
            csr_ready = !start;
            if (start) begin
               cmd.accept = 1'b1;
               unique case (req_type)
                  lrss_pkg::REQ_LOAD: state_in = lrss_pkg::S_LOAD;
                  lrss_pkg::REQ_SORT: state_in = lrss_pkg::S_SETUP;
                  lrss_pkg::REQ_READ: state_in = lrss_pkg::S_RD0;
                  default:            state_in = lrss_pkg::S_NOP;
               endcase
            end else if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               state_in      = lrss_pkg::S_DIV;
            end
         end
         lrss_pkg::S_DIV: begin
            cmd.op = lrss_pkg::OP_DIV;
            if (stat.div_last) state_in = lrss_pkg::S_IDLE;
         end
         lrss_pkg::S_LOAD: begin
            cmd.op   = lrss_pkg::OP_LOAD;
            state_in = lrss_pkg::S_IDLE;
         end
         lrss_pkg::S_NOP: begin
            cmd.op   = lrss_pkg::OP_NOP;
            state_in = lrss_pkg::S_IDLE;
         end
         lrss_pkg::S_RD0: begin
            cmd.op   = lrss_pkg::OP_RD0;
            state_in = stat.can_read ? lrss_pkg::S_RD1 : lrss_pkg::S_IDLE;
         end
         lrss_pkg::S_RD1: begin
            cmd.op   = lrss_pkg::OP_RD1;
            state_in = lrss_pkg::S_RD2;
         end
         lrss_pkg::S_RD2: begin
            cmd.op   = lrss_pkg::OP_RD2;
            state_in = lrss_pkg::S_IDLE;
         end
         lrss_pkg::S_SETUP: begin
            cmd.op   = lrss_pkg::OP_SETUP;
            state_in = lrss_pkg::S_CHK;
         end
         lrss_pkg::S_CHK: begin
            state_in = stat.n_zero ? lrss_pkg::S_DONE : lrss_pkg::S_INIT;
         end
         lrss_pkg::S_INIT: begin
            cmd.op = lrss_pkg::OP_INIT;
            if (stat.i_last) state_in = lrss_pkg::S_CLR;
         end
         lrss_pkg::S_CLR: begin
            cmd.op = lrss_pkg::OP_CLR;
            if (stat.b_last) state_in = lrss_pkg::S_CNT0;
         end
         lrss_pkg::S_CNT0: begin
            cmd.op   = lrss_pkg::OP_CNT0;
            state_in = lrss_pkg::S_CNT1;
         end
         lrss_pkg::S_CNT1: begin
            cmd.op   = lrss_pkg::OP_CNT1;
            state_in = lrss_pkg::S_CNT2;
         end
         lrss_pkg::S_CNT2: begin
            cmd.op   = lrss_pkg::OP_CNT2;
            state_in = lrss_pkg::S_CNT3;
         end
         lrss_pkg::S_CNT3: begin
            cmd.op   = lrss_pkg::OP_CNT3;
            state_in = stat.i_last ? lrss_pkg::S_PFX0 : lrss_pkg::S_CNT0;
         end
         lrss_pkg::S_PFX0: begin
            cmd.op   = lrss_pkg::OP_PFX0;
            state_in = lrss_pkg::S_PFX1;
         end
         lrss_pkg::S_PFX1: begin
            cmd.op   = lrss_pkg::OP_PFX1;
            state_in = stat.b_last ? lrss_pkg::S_SCT0 : lrss_pkg::S_PFX0;
         end
         lrss_pkg::S_SCT0: begin
            cmd.op   = lrss_pkg::OP_SCT0;
            state_in = lrss_pkg::S_SCT1;
         end
         lrss_pkg::S_SCT1: begin
            cmd.op   = lrss_pkg::OP_SCT1;
            state_in = lrss_pkg::S_SCT2;
         end
         lrss_pkg::S_SCT2: begin
            cmd.op   = lrss_pkg::OP_SCT2;
            state_in = lrss_pkg::S_SCT3;
         end
         lrss_pkg::S_SCT3: begin
            cmd.op   = lrss_pkg::OP_SCT3;
            state_in = stat.i_last ? lrss_pkg::S_CPY0 : lrss_pkg::S_SCT0;
         end
         lrss_pkg::S_CPY0: begin
            cmd.op   = lrss_pkg::OP_CPY0;
            state_in = lrss_pkg::S_CPY1;
         end
         lrss_pkg::S_CPY1: begin
            cmd.op = lrss_pkg::OP_CPY1;
            if (!stat.i_last) begin
               state_in = lrss_pkg::S_CPY0;
            end else if (stat.p_zero) begin
               state_in = lrss_pkg::S_DONE;
            end else begin
               state_in = lrss_pkg::S_CLR;
            end
         end
         lrss_pkg::S_DONE: begin
            cmd.op   = lrss_pkg::OP_DONE;
            state_in = lrss_pkg::S_IDLE;
         end
         default: state_in = lrss_pkg::S_IDLE;
      endcase
   end

endmodule

>>> rtl/lrss_datapath.sv
module lrss_datapath #(
   parameter int MAX_STRINGS = 256,
   parameter int MAX_LEN     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lrss_pkg::dp_cmd_type     cmd,
   output lrss_pkg::dp_status_type  stat,
   input  logic [6:0]              req_char_code,
   input  logic [4:0]              csr_data,
   output logic                    rsp_valid,
   output logic [6:0]              rsp_out_char,
   output logic                    rsp_end_of_string,
   output logic                    rsp_end_of_set,
   output logic [8:0]              rsp_strings_held,
   output logic [1:0]              rsp_status
);

   localparam int SW    = $clog2(MAX_STRINGS);
   localparam int NW    = $clog2(MAX_STRINGS + 1);
   localparam int LW    = $clog2(MAX_LEN + 1);
   localparam int PW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DEPTH = MAX_STRINGS * MAX_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int DCW   = $clog2(CW);
   localparam int XW    = SW + LW + 1;
   localparam int BW    = lrss_pkg::BW;

   logic [LW-1:0]  len_ff, len_in;
   logic [CW-1:0]  chars_ff, chars_in;
   logic [CW-1:0]  nfull_ff, nfull_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic           sorted_ff, sorted_in;
   logic [CW-1:0]  rp_ff, rp_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [PW-1:0]  j_ff, j_in;
   logic [PW-1:0]  rj_ff, rj_in;
   logic [SW-1:0]  i_ff, i_in;
   logic [BW-1:0]  b_ff, b_in;
   logic [PW-1:0]  p_ff, p_in;
   logic [NW-1:0]  run_ff, run_in;
   logic [BW-1:0]  key_ff, key_in;
   logic [SW-1:0]  ord_ff, ord_in;
   logic           partial_ff, partial_in;
   logic [6:0]     code_ff, code_in;
   logic [LW:0]    dr_ff, dr_in;
   logic [CW-1:0]  dq_ff, dq_in;
   logic [DCW-1:0] dc_ff, dc_in;
   logic           eos_ff, eos_in;
   logic           eoset_ff, eoset_in;

   logic           ov_ff, ov_in;
   logic [6:0]     oc_ff, oc_in;
   logic           oeos_ff, oeos_in;
   logic           oeoset_ff, oeoset_in;
   logic [1:0]     ost_ff, ost_in;

   logic           st_we, st_re;
   logic [AW-1:0]  st_waddr, st_raddr;
   logic [6:0]     st_wdata, st_rdata;
   logic           oa_we, oa_re;
   logic [SW-1:0]  oa_waddr, oa_raddr, oa_wdata, oa_rdata;
   logic           ob_we, ob_re;
   logic [SW-1:0]  ob_waddr, ob_raddr, ob_wdata, ob_rdata;
   logic           bc_we, bc_re;
   logic [BW-1:0]  bc_waddr, bc_raddr;
   logic [NW-1:0]  bc_wdata, bc_rdata;

   logic [NW-1:0]  n_cap;
   logic [XW-1:0]  addr_wide;
   logic [PW-1:0]  pos_sel;
   logic [LW:0]    dshift;
   logic           dge;
   logic [6:0]     code_sat;
   logic           full;
   logic [4:0]     len_sat;

   lrss_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_store (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
   );

   lrss_ram #(.WIDTH(SW), .DEPTH(MAX_STRINGS)) u_order_a (
      .clock(clock), .we(oa_we), .waddr(oa_waddr), .wdata(oa_wdata),
      .re(oa_re), .raddr(oa_raddr), .rdata(oa_rdata)
   );

   lrss_ram #(.WIDTH(SW), .DEPTH(MAX_STRINGS)) u_order_b (
      .clock(clock), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
      .re(ob_re), .raddr(ob_raddr), .rdata(ob_rdata)
   );

   lrss_ram #(.WIDTH(NW), .DEPTH(lrss_pkg::BUCKETS)) u_counts (
      .clock(clock), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
      .re(bc_re), .raddr(bc_raddr), .rdata(bc_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LW'(1);
         chars_ff  <= '0;
         nfull_ff  <= '0;
         rem_ff    <= '0;
         sorted_ff <= 1'b0;
         rp_ff     <= '0;
         s_ff      <= '0;
         j_ff      <= '0;
         i_ff      <= '0;
         b_ff      <= '0;
         p_ff      <= '0;
         dc_ff     <= '0;
         ov_ff     <= 1'b0;
      end else begin
         len_ff    <= len_in;
         chars_ff  <= chars_in;
         nfull_ff  <= nfull_in;
         rem_ff    <= rem_in;
         sorted_ff <= sorted_in;
         rp_ff     <= rp_in;
         s_ff      <= s_in;
         j_ff      <= j_in;
         i_ff      <= i_in;
         b_ff      <= b_in;
         p_ff      <= p_in;
         dc_ff     <= dc_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rj_ff      <= rj_in;
      run_ff     <= run_in;
      key_ff     <= key_in;
      ord_ff     <= ord_in;
      partial_ff <= partial_in;
      code_ff    <= code_in;
      dr_ff      <= dr_in;
      dq_ff      <= dq_in;
      eos_ff     <= eos_in;
      eoset_ff   <= eoset_in;
      oc_ff      <= oc_in;
      oeos_ff    <= oeos_in;
      oeoset_ff  <= oeoset_in;
      ost_ff     <= ost_in;
   end

   assign n_cap   = (nfull_ff > CW'(MAX_STRINGS)) ? NW'(MAX_STRINGS) : NW'(nfull_ff);
   assign full    = (nfull_ff >= CW'(MAX_STRINGS));
   assign pos_sel = (cmd.op == lrss_pkg::OP_RD1) ? rj_ff : p_ff;
   assign addr_wide = XW'(oa_rdata) * XW'(len_ff) + XW'(pos_sel);
   assign dshift  = {dr_ff[LW-1:0], dq_ff[CW-1]};
   assign dge     = (dshift >= (LW+1)'(len_ff));
   assign len_sat = (csr_data == 5'd0) ? 5'd1 : csr_data;

   always_comb begin
      if (req_char_code < 7'(lrss_pkg::FIRST_CODE)) begin
         code_sat = 7'(lrss_pkg::FIRST_CODE);
      end else if (req_char_code > 7'(lrss_pkg::LAST_CODE)) begin
         code_sat = 7'(lrss_pkg::LAST_CODE);
      end else begin
         code_sat = req_char_code;
      end
   end

   always_comb begin
      stat.can_read = sorted_ff && (rp_ff < chars_ff);
      stat.n_zero   = (nfull_ff == '0);
      stat.i_last   = ((CW'(i_ff) + CW'(1)) == nfull_ff);
      stat.b_last   = (b_ff == BW'(lrss_pkg::BUCKETS - 1));
      stat.p_zero   = (p_ff == '0);
      stat.div_last = (dc_ff == DCW'(CW - 1));
   end

   always_comb begin
      len_in     = len_ff;
      chars_in   = chars_ff;
      nfull_in   = nfull_ff;
      rem_in     = rem_ff;
      sorted_in  = sorted_ff;
      rp_in      = rp_ff;
      s_in       = s_ff;
      j_in       = j_ff;
      rj_in      = rj_ff;
      i_in       = i_ff;
      b_in       = b_ff;
      p_in       = p_ff;
      run_in     = run_ff;
      key_in     = key_ff;
      ord_in     = ord_ff;
      partial_in = partial_ff;
      code_in    = code_ff;
      dr_in      = dr_ff;
      dq_in      = dq_ff;
      dc_in      = dc_ff;
      eos_in     = eos_ff;
      eoset_in   = eoset_ff;
      ov_in      = 1'b0;
      oc_in      = 7'd0;
      oeos_in    = 1'b0;
      oeoset_in  = 1'b0;
      ost_in     = lrss_pkg::ST_OK;

      st_we    = 1'b0;
      st_waddr = chars_ff[AW-1:0];
      st_wdata = code_ff;
      st_re    = 1'b0;
      st_raddr = addr_wide[AW-1:0];
      oa_we    = 1'b0;
      oa_waddr = i_ff;
      oa_wdata = i_ff;
      oa_re    = 1'b0;
      oa_raddr = i_ff;
      ob_we    = 1'b0;
      ob_waddr = bc_rdata[SW-1:0];
      ob_wdata = ord_ff;
      ob_re    = 1'b0;
      ob_raddr = i_ff;
      bc_we    = 1'b0;
      bc_waddr = key_ff;
      bc_wdata = bc_rdata + NW'(1);
      bc_re    = 1'b0;
      bc_raddr = key_ff;

      if (cmd.accept) begin
         code_in = code_sat;
      end
      if (cmd.cfg_write) begin
         if (32'(len_sat) > MAX_LEN) begin
            len_in = LW'(MAX_LEN);
         end else begin
            len_in = LW'(len_sat);
         end
         sorted_in = 1'b0;
         rp_in     = '0;
         s_in      = '0;
         j_in      = '0;
         dr_in     = '0;
         dq_in     = chars_ff;
         dc_in     = '0;
      end

      case (cmd.op) inside
         lrss_pkg::OP_DIV: begin
            dq_in = {dq_ff[CW-2:0], dge};
            dr_in = dge ? (dshift - (LW+1)'(len_ff)) : dshift;
            dc_in = dc_ff + DCW'(1);
            if (stat.div_last) begin
               nfull_in = {dq_ff[CW-2:0], dge};
               rem_in   = dge ? PW'(dshift - (LW+1)'(len_ff)) : PW'(dshift);
            end
         end
         lrss_pkg::OP_LOAD: begin
            ov_in = 1'b1;
            if (full) begin
               ost_in = lrss_pkg::ST_FULL;
            end else begin
               st_we     = 1'b1;
               chars_in  = chars_ff + CW'(1);
               sorted_in = 1'b0;
               rp_in     = '0;
               s_in      = '0;
               j_in      = '0;
               if ((LW'(rem_ff) + LW'(1)) == len_ff) begin
                  rem_in   = '0;
                  nfull_in = nfull_ff + CW'(1);
               end else begin
                  rem_in = rem_ff + PW'(1);
               end
            end
         end
         lrss_pkg::OP_NOP: begin
            ov_in = 1'b1;
         end
         lrss_pkg::OP_RD0: begin
            if (stat.can_read) begin
               oa_re    = 1'b1;
               oa_raddr = s_ff;
               rj_in    = j_ff;
               eos_in   = ((LW'(j_ff) + LW'(1)) == len_ff);
               eoset_in = ((rp_ff + CW'(1)) == chars_ff);
               rp_in    = rp_ff + CW'(1);
               if ((LW'(j_ff) + LW'(1)) == len_ff) begin
                  j_in = '0;
                  s_in = s_ff + SW'(1);
               end else begin
                  j_in = j_ff + PW'(1);
               end
            end else begin
               ov_in  = 1'b1;
               ost_in = lrss_pkg::ST_NO_READ;
            end
         end
         lrss_pkg::OP_RD1: begin
            st_re = 1'b1;
         end
         lrss_pkg::OP_RD2: begin
            ov_in     = 1'b1;
            oc_in     = st_rdata;
            oeos_in   = eos_ff;
            oeoset_in = eoset_ff;
         end
         lrss_pkg::OP_SETUP: begin
            partial_in = (rem_ff != '0) || (nfull_ff > CW'(MAX_STRINGS));
            chars_in   = CW'(XW'(n_cap) * XW'(len_ff));
            nfull_in   = CW'(n_cap);
            rem_in     = '0;
            i_in       = '0;
            b_in       = '0;
            p_in       = PW'(len_ff - LW'(1));
         end
         lrss_pkg::OP_INIT: begin
            oa_we = 1'b1;
            i_in  = stat.i_last ? '0 : i_ff + SW'(1);
         end
         lrss_pkg::OP_CLR: begin
            bc_we    = 1'b1;
            bc_waddr = b_ff;
            bc_wdata = '0;
            b_in     = stat.b_last ? '0 : b_ff + BW'(1);
            if (stat.b_last) i_in = '0;
         end
         lrss_pkg::OP_CNT0, lrss_pkg::OP_SCT0: begin
            oa_re = 1'b1;
         end
         lrss_pkg::OP_CNT1, lrss_pkg::OP_SCT1: begin
            st_re  = 1'b1;
            ord_in = oa_rdata;
         end
         lrss_pkg::OP_CNT2, lrss_pkg::OP_SCT2: begin
            key_in   = BW'(st_rdata - 7'(lrss_pkg::FIRST_CODE));
            bc_re    = 1'b1;
            bc_raddr = BW'(st_rdata - 7'(lrss_pkg::FIRST_CODE));
         end
         lrss_pkg::OP_CNT3: begin
            bc_we = 1'b1;
            i_in  = stat.i_last ? '0 : i_ff + SW'(1);
            if (stat.i_last) begin
               b_in   = '0;
               run_in = '0;
            end
         end
         lrss_pkg::OP_PFX0: begin
            bc_re    = 1'b1;
            bc_raddr = b_ff;
         end
         lrss_pkg::OP_PFX1: begin
            bc_we    = 1'b1;
            bc_waddr = b_ff;
            bc_wdata = run_ff;
            run_in   = run_ff + bc_rdata;
            b_in     = stat.b_last ? '0 : b_ff + BW'(1);
            if (stat.b_last) i_in = '0;
         end
         lrss_pkg::OP_SCT3: begin
            bc_we = 1'b1;
            ob_we = 1'b1;
            i_in  = stat.i_last ? '0 : i_ff + SW'(1);
         end
         lrss_pkg::OP_CPY0: begin
            ob_re = 1'b1;
         end
         lrss_pkg::OP_CPY1: begin
            oa_we    = 1'b1;
            oa_wdata = ob_rdata;
            i_in     = stat.i_last ? '0 : i_ff + SW'(1);
            if (stat.i_last) begin
               b_in = '0;
               if (!stat.p_zero) p_in = p_ff - PW'(1);
            end
         end
         lrss_pkg::OP_DONE: begin
            ov_in     = 1'b1;
            ost_in    = partial_ff ? lrss_pkg::ST_PARTIAL : lrss_pkg::ST_OK;
            sorted_in = 1'b1;
            rp_in     = '0;
            s_in      = '0;
            j_in      = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid         = ov_ff;
   assign rsp_out_char      = oc_ff;
   assign rsp_end_of_string = oeos_ff;
   assign rsp_end_of_set    = oeoset_ff;
   assign rsp_strings_held  = 9'(n_cap);
   assign rsp_status        = ost_ff;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int NSTR = 256;
   localparam int NLEN = 16;
   localparam logic [1:0] REQ_NOP = 2'd3;
   localparam int STALL_LIMIT = 200000;

   typedef enum logic [1:0] { K_REQ, K_CFG, K_DRAIN } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0]    rt;
      logic [6:0]    ch;
      logic [4:0]    cfg;
   } step_type;

   typedef struct {
      logic [6:0] out_char;
      logic       eos;
      logic       eoset;
      logic [8:0] held;
      logic [1:0] status;
   } sorted_rsp_type;

   logic       clock, reset, start, busy, csr_valid, csr_ready;
   logic [1:0] req_type;
   logic [6:0] req_char_code;
   logic [4:0] csr_data;
   logic       rsp_valid, rsp_end_of_string, rsp_end_of_set;
   logic [6:0] rsp_out_char;
   logic [8:0] rsp_strings_held;
   logic [1:0] rsp_status;

   lsd_radix_string_sorter_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_char_code(req_char_code),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_out_char(rsp_out_char),
      .rsp_end_of_string(rsp_end_of_string), .rsp_end_of_set(rsp_end_of_set),
      .rsp_strings_held(rsp_strings_held), .rsp_status(rsp_status)
   );

   step_type       pending_q[$];
   sorted_rsp_type sorted_rsp_q[$];
   int             mismatches = 0;
   int             n_load = 0, n_sort = 0, n_read = 0, n_nop = 0, n_cfg = 0, n_rsp = 0;
   bit             gen_done = 0;

   // predictor state
   logic [6:0] char_mem[NSTR*NLEN];
   int         perm[NSTR];
   int         perm_tmp[NSTR];
   int         pred_chars = 0, pred_rdpos = 0, pred_len_reg = 1;
   bit         pred_sorted = 0;

   // generator's own view, used to shape stimulus and bound sort cost
   int gen_chars = 0, gen_len = 1, gen_items = 0;
   int sort_budget = 600000;

   function automatic int eff_len(int v);
      if (v < 1) return 1;
      if (v > NLEN) return NLEN;
      return v;
   endfunction

   function automatic int pred_held();
      int n;
      n = pred_chars / eff_len(pred_len_reg);
      return (n > NSTR) ? NSTR : n;
   endfunction

   function automatic sorted_rsp_type predict_sorted(logic [1:0] rt, logic [6:0] code);
      sorted_rsp_type r;
      int len, n, total, s, j, k, run, c;
      int counts[lrss_pkg::BUCKETS];
      len = eff_len(pred_len_reg);
      r = '{default: '0};
      case (rt)
         lrss_pkg::REQ_LOAD: begin
            if (pred_chars >= NSTR * len) r.status = lrss_pkg::ST_FULL;
            else begin
               if (code < lrss_pkg::FIRST_CODE) code = 7'(lrss_pkg::FIRST_CODE);
               if (code > lrss_pkg::LAST_CODE) code = 7'(lrss_pkg::LAST_CODE);
               char_mem[pred_chars] = code;
               pred_chars++;
               pred_sorted = 0;
               pred_rdpos = 0;
            end
         end
         lrss_pkg::REQ_SORT: begin
            n = pred_held();
            if (pred_chars != n * len) r.status = lrss_pkg::ST_PARTIAL;
            pred_chars = n * len;
            for (int i = 0; i < n; i++) perm[i] = i;
            for (int p = len - 1; p >= 0; p--) begin
               for (int b = 0; b < lrss_pkg::BUCKETS; b++) counts[b] = 0;
               for (int i = 0; i < n; i++)
                  counts[char_mem[perm[i]*len+p] - lrss_pkg::FIRST_CODE]++;
               run = 0;
               for (int b = 0; b < lrss_pkg::BUCKETS; b++) begin
                  c = counts[b];
                  counts[b] = run;
                  run += c;
               end
               for (int i = 0; i < n; i++) begin
                  k = char_mem[perm[i]*len+p] - lrss_pkg::FIRST_CODE;
                  perm_tmp[counts[k]] = perm[i];
                  counts[k]++;
               end
               for (int i = 0; i < n; i++) perm[i] = perm_tmp[i];
            end
            pred_sorted = 1;
            pred_rdpos = 0;
         end
         lrss_pkg::REQ_READ: begin
            total = pred_held() * len;
            if (!pred_sorted || pred_rdpos >= total) r.status = lrss_pkg::ST_NO_READ;
            else begin
               s = pred_rdpos / len;
               j = pred_rdpos % len;
               r.out_char = char_mem[perm[s]*len+j];
               r.eos = (j == len - 1);
               r.eoset = (pred_rdpos == total - 1);
               pred_rdpos++;
            end
         end
         default: ;
      endcase
      r.held = 9'(pred_held());
      return r;
   endfunction

   // stimulus helpers
   task automatic push_req(logic [1:0] rt, logic [6:0] ch);
      int len;
      len = eff_len(gen_len);
      pending_q.push_back('{K_REQ, rt, ch, 5'd0});
      gen_items++;
      if (rt == lrss_pkg::REQ_LOAD && gen_chars < NSTR * len) gen_chars++;
      if (rt == lrss_pkg::REQ_SORT) begin
         if (gen_chars / len > NSTR) gen_chars = NSTR * len;
         else gen_chars = (gen_chars / len) * len;
      end
   endtask

   task automatic push_cfg(logic [4:0] v);
      pending_q.push_back('{K_CFG, 2'd0, 7'd0, v});
      gen_len = int'(v);
   endtask

   task automatic push_sort();
      int len, n, cost;
      len = eff_len(gen_len);
      n = gen_chars / len;
      if (n > NSTR) n = NSTR;
      cost = len * (285 + 10 * n) + n + 10;
      if (cost <= sort_budget) begin
         sort_budget -= cost;
         push_req(lrss_pkg::REQ_SORT, 7'd0);
      end else begin
         push_req(lrss_pkg::REQ_READ, 7'd0);
      end
   endtask

   function automatic logic [6:0] rand_print();
      return 7'($urandom_range(lrss_pkg::FIRST_CODE, lrss_pkg::LAST_CODE));
   endfunction

   initial begin
      int n, len, reads;
      // directed
      push_req(lrss_pkg::REQ_READ, 7'd0);
      push_req(REQ_NOP, 7'h55);
      push_req(lrss_pkg::REQ_SORT, 7'd0);
      push_req(lrss_pkg::REQ_READ, 7'd0);
      push_cfg(5'd0);
      push_req(lrss_pkg::REQ_LOAD, 7'd0);
      push_req(lrss_pkg::REQ_LOAD, 7'd127);
      push_req(lrss_pkg::REQ_LOAD, 7'd32);
      push_req(lrss_pkg::REQ_LOAD, 7'd126);
      push_req(lrss_pkg::REQ_LOAD, 7'("b"));
      push_req(lrss_pkg::REQ_LOAD, 7'("a"));
      push_sort();
      for (int i = 0; i < 7; i++) push_req(lrss_pkg::REQ_READ, 7'd0);
      push_cfg(5'd31);
      for (int i = 0; i < 10; i++)
         push_req(lrss_pkg::REQ_LOAD, (i % 2) ? 7'("z") : 7'("!"));
      push_sort();
      push_req(lrss_pkg::REQ_READ, 7'd0);
      push_req(lrss_pkg::REQ_LOAD, 7'("q"));
      push_req(lrss_pkg::REQ_READ, 7'd0);
      pending_q.push_back('{K_DRAIN, 2'd0, 7'd0, 5'd0});
      // fill the store at length 2, then shrink the length so strings overflow
      push_cfg(5'd2);
      while (gen_chars < NSTR * 2) push_req(lrss_pkg::REQ_LOAD, rand_print());
      push_req(lrss_pkg::REQ_LOAD, 7'("x"));
      push_cfg(5'd1);
      push_req(lrss_pkg::REQ_LOAD, 7'("y"));
      push_sort();
      for (int i = 0; i < 6; i++) push_req(lrss_pkg::REQ_READ, 7'd0);
      push_cfg(5'd16);
      push_sort();
      for (int i = 0; i < 20; i++) push_req(lrss_pkg::REQ_READ, 7'd0);
      // random
      while (gen_items < 900) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 2) == 0) begin
               if ($urandom_range(0, 5) == 0)
                  push_cfg($urandom_range(0, 1) ? 5'd0 : 5'd31);
               else
                  push_cfg(5'($urandom_range(1, 20)));
            end
            len = eff_len(gen_len);
            n = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            for (int i = 0; i < n * len; i++)
               push_req(lrss_pkg::REQ_LOAD, ($urandom_range(0, 3) == 0) ?
                        7'($urandom_range(lrss_pkg::FIRST_CODE, lrss_pkg::FIRST_CODE + 3)) :
                        rand_print());
            if ($urandom_range(0, 3) == 0)
               for (int i = 0; i < $urandom_range(1, len); i++)
                  push_req(lrss_pkg::REQ_LOAD, rand_print());
            push_sort();
            reads = $urandom_range(0, 60);
            for (int i = 0; i < reads; i++) push_req(lrss_pkg::REQ_READ, 7'd0);
            if ($urandom_range(0, 5) == 0)
               pending_q.push_back('{K_DRAIN, 2'd0, 7'd0, 5'd0});
         end else begin
            for (int i = 0; i < $urandom_range(1, 6); i++)
               push_req(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
         end
      end
      gen_done = 1;
   end

   // clock and reset
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
   end

   // driver
   int       gap = 0;
   int       settle = 0;
   step_type cur;

   always @(posedge clock) begin : drv
      logic st, cv;
      if (reset) begin
         start <= 0;
         req_type <= REQ_NOP;
         req_char_code <= '0;
         csr_valid <= 0;
         csr_data <= '0;
      end else begin
         st = start;
         cv = csr_valid;
         if (start && !busy) begin
            sorted_rsp_q.push_back(predict_sorted(req_type, req_char_code));
            case (req_type)
               lrss_pkg::REQ_LOAD: n_load++;
               lrss_pkg::REQ_SORT: n_sort++;
               lrss_pkg::REQ_READ: n_read++;
               default:            n_nop++;
            endcase
            st = 0;
            if (pending_q.size() > 120 && $urandom_range(0, 7) == 0)
               gap = $urandom_range(1, 16);
         end
         if (csr_valid && csr_ready) begin
            pred_len_reg = int'(csr_data);
            pred_sorted = 0;
            pred_rdpos = 0;
            n_cfg++;
            cv = 0;
         end
         if (!st && !cv && gen_done) begin
            if (gap > 0) gap--;
            else if (pending_q.size() > 0) begin
               cur = pending_q[0];
               if (cur.kind == K_REQ) begin
                  void'(pending_q.pop_front());
                  req_type <= cur.rt;
                  req_char_code <= cur.ch;
                  st = 1;
                  settle = 0;
               end else if (sorted_rsp_q.size() == 0 && !busy) begin
                  if (settle < 8) settle++;
                  else begin
                     void'(pending_q.pop_front());
                     settle = 0;
                     if (cur.kind == K_CFG) begin
                        csr_data <= cur.cfg;
                        cv = 1;
                     end
                  end
               end else settle = 0;
            end
         end
         start <= st;
         csr_valid <= cv;
      end
   end

   // monitor
   always @(posedge clock) begin : mon
      sorted_rsp_type e;
      if (!reset && rsp_valid) begin
         n_rsp++;
         if (sorted_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer: char %0d status %0d",
                                           rsp_out_char, rsp_status);
         end else begin
            e = sorted_rsp_q.pop_front();
            if (rsp_out_char !== e.out_char || rsp_end_of_string !== e.eos ||
                rsp_end_of_set !== e.eoset || rsp_strings_held !== e.held ||
                rsp_status !== e.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: exp char %0d eos %0b eoset %0b held %0d st %0d,",
                           $realtime, e.out_char, e.eos, e.eoset, e.held, e.status);
                  $display("   got char %0d eos %0b eoset %0b held %0d st %0d",
                           rsp_out_char, rsp_end_of_string, rsp_end_of_set,
                           rsp_strings_held, rsp_status);
               end
            end
         end
      end
   end

   // watchdog
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (gen_done);
      @(posedge clock);
      while (pending_q.size() > 0 || start || csr_valid || sorted_rsp_q.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d loads, %0d sorts, %0d reads, %0d no-ops, %0d length writes",
               n_load, n_sort, n_read, n_nop, n_cfg);
      $display("%0d results checked, %0d mismatches", n_rsp, mismatches);
      if (mismatches == 0 && sorted_rsp_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> lsd_radix_string_sorter_core.f
rtl/lrss_pkg.sv
rtl/lrss_ram.sv
rtl/lrss_ctrl.sv
rtl/lrss_datapath.sv
rtl/lsd_radix_string_sorter_core.sv
tb/tb_top.sv
